FILE: hw/rtl/sblp_pkg.sv
// ----------------------------------------------------------------------------
// sblp_pkg
// Shared types and codes for the size-budgeted LRU pool.
// ----------------------------------------------------------------------------
package sblp_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam logic [23:0] USED_MAX = 24'hFFFFFF;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_TOUCH   = 2'd1;
    localparam logic [1:0] CMD_UNLOAD  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_STAMP = 2'd1;
    localparam logic [1:0] WR_LOAD  = 2'd2;
    localparam logic [1:0] WR_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] item_key;
        logic [15:0] item_id;
        logic [15:0] item_size_mb;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] result_id;
        logic        was_hit;
        logic [1:0]  status;
        logic [23:0] used_total_mb;
        logic [31:0] reload_count;
        logic [31:0] eviction_count;
        logic        is_last;
    } result_t;

    // write broadcast from the controller to the cells
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [15:0] id;
        logic [15:0] size;
        logic [31:0] stamp;
    } wr_t;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic        m_found;
        logic [15:0] m_id;
        logic [15:0] m_size;
        logic        f_found;
        logic        o_found;
        logic [31:0] o_age;
        logic [15:0] o_id;
        logic [15:0] o_size;
    } carry_t;

endpackage

FILE: hw/rtl/sblp_cell.sv
// ----------------------------------------------------------------------------
// sblp_cell
// One table slot plus one stage of the scan chain: first match, first free
// slot and oldest slot are merged into the carry from the left neighbor.
// ----------------------------------------------------------------------------
module sblp_cell
    import sblp_pkg::*;
#(
    parameter int IW       = 4,
    parameter int CELL_IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          id_mode,
    input  logic [31:0]   scan_key,
    input  logic [15:0]   scan_id,
    input  logic [31:0]   clock_now,
    input  wr_t           wr,
    input  logic [IW-1:0] wr_idx,
    input  carry_t        cin,
    input  logic [IW-1:0] m_idx_in,
    input  logic [IW-1:0] f_idx_in,
    input  logic [IW-1:0] o_idx_in,
    output carry_t        cout,
    output logic [IW-1:0] m_idx_out,
    output logic [IW-1:0] f_idx_out,
    output logic [IW-1:0] o_idx_out
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [15:0] id_reg;
    logic [15:0] size_reg;
    logic [31:0] stamp_reg;

    carry_t        carry_reg, carry_next;
    logic [IW-1:0] m_idx_reg, m_idx_next;
    logic [IW-1:0] f_idx_reg, f_idx_next;
    logic [IW-1:0] o_idx_reg, o_idx_next;

    logic        sel;
    logic        hit;
    logic [31:0] age;

    assign sel = (wr_idx == MY_IDX);
    assign hit = valid_reg && (id_mode ? (id_reg == scan_id) : (key_reg == scan_key));
    assign age = clock_now - stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && wr.op == WR_LOAD)
        begin
            valid_reg <= 1'b1;
        end
        else if (sel && wr.op == WR_CLEAR)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.op == WR_LOAD)
        begin
            key_reg  <= wr.key;
            id_reg   <= wr.id;
            size_reg <= wr.size;
        end
        if (sel && (wr.op == WR_LOAD || wr.op == WR_STAMP))
        begin
            stamp_reg <= wr.stamp;
        end
    end

    always_comb
    begin
        carry_next = cin;
        m_idx_next = m_idx_in;
        f_idx_next = f_idx_in;
        o_idx_next = o_idx_in;
        if (!cin.m_found && hit)
        begin
            carry_next.m_found = 1'b1;
            carry_next.m_id    = id_reg;
            carry_next.m_size  = size_reg;
            m_idx_next         = MY_IDX;
        end
        if (!cin.f_found && !valid_reg)
        begin
            carry_next.f_found = 1'b1;
            f_idx_next         = MY_IDX;
        end
        // strictly older wins, so ties stay with the lower index
        if (valid_reg && (!cin.o_found || age > cin.o_age))
        begin
            carry_next.o_found = 1'b1;
            carry_next.o_age   = age;
            carry_next.o_id    = id_reg;
            carry_next.o_size  = size_reg;
            o_idx_next         = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            m_idx_reg <= '0;
            f_idx_reg <= '0;
            o_idx_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            m_idx_reg <= m_idx_next;
            f_idx_reg <= f_idx_next;
            o_idx_reg <= o_idx_next;
        end
    end

    assign cout      = carry_reg;
    assign m_idx_out = m_idx_reg;
    assign f_idx_out = f_idx_reg;
    assign o_idx_out = o_idx_reg;

endmodule

FILE: hw/rtl/size_budget_lru_pool_top.sv
// ----------------------------------------------------------------------------
// size_budget_lru_pool_top
// Size-budgeted LRU table of resident items with a scan chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are transferred with start while busy is low; item carries cmd,
//   key, id and size. Each command yields one or more results on result, each
//   marked by done for exactly one cycle; the receiver cannot stall, so every
//   result is taken as it appears. Eviction notices (kind 0) come first, the
//   final answer (is_last) ends the command.
//   Every table scan runs through the chain of TABLE_ENTRIES cells, one cell
//   per cycle, then the decide state acts on the result of the last cell.
//   Touch, unload and a request hit take one scan. A request miss takes one
//   more scan per eviction plus one for the insert. An undefined command
//   answers from idle without a scan. busy stays high until the final answer
//   is driven, so one command is in work at a time. size_limit_mb is written
//   over the cfg channel; cfg_ready is high while idle. Reset empties the
//   table and clears the counters and the budget.
// ----------------------------------------------------------------------------
module size_budget_lru_pool_top
    import sblp_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_CNT = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_EVICT = 2'd1;
    localparam logic [1:0] PH_ID    = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    item_t         item_reg, item_next;
    logic [19:0]   limit_reg;
    logic [23:0]   used_reg, used_next;
    logic [31:0]   clock_reg, clock_next;
    logic [31:0]   reload_reg, reload_next;
    logic [31:0]   evict_reg, evict_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    wr_t           wr;
    logic [IW-1:0] wr_idx;

    carry_t        carry   [TABLE_ENTRIES];
    logic [IW-1:0] m_idx   [TABLE_ENTRIES];
    logic [IW-1:0] f_idx   [TABLE_ENTRIES];
    logic [IW-1:0] o_idx   [TABLE_ENTRIES];
    carry_t        scan;

    logic [24:0]   need;
    logic          over;
    logic [23:0]   used_less_m;
    logic [23:0]   used_less_o;
    logic [24:0]   add_sum;
    logic [23:0]   used_ins;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                sblp_cell #(.IW(IW), .CELL_IDX(g)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .id_mode   (phase_reg != PH_KEY),
                    .scan_key  (item_reg.item_key),
                    .scan_id   (item_reg.item_id),
                    .clock_now (clock_reg),
                    .wr        (wr),
                    .wr_idx    (wr_idx),
                    .cin       ('0),
                    .m_idx_in  ('0),
                    .f_idx_in  ('0),
                    .o_idx_in  ('0),
                    .cout      (carry[g]),
                    .m_idx_out (m_idx[g]),
                    .f_idx_out (f_idx[g]),
                    .o_idx_out (o_idx[g])
                );
            end
            else
            begin : g_body
                sblp_cell #(.IW(IW), .CELL_IDX(g)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .id_mode   (phase_reg != PH_KEY),
                    .scan_key  (item_reg.item_key),
                    .scan_id   (item_reg.item_id),
                    .clock_now (clock_reg),
                    .wr        (wr),
                    .wr_idx    (wr_idx),
                    .cin       (carry[g-1]),
                    .m_idx_in  (m_idx[g-1]),
                    .f_idx_in  (f_idx[g-1]),
                    .o_idx_in  (o_idx[g-1]),
                    .cout      (carry[g]),
                    .m_idx_out (m_idx[g]),
                    .f_idx_out (f_idx[g]),
                    .o_idx_out (o_idx[g])
                );
            end
        end
    endgenerate

    assign scan = carry[TABLE_ENTRIES-1];

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    assign need        = {1'b0, used_reg} + {9'd0, item_reg.item_size_mb};
    assign over        = need > {5'd0, limit_reg};
    assign used_less_m = ({8'd0, scan.m_size} > used_reg) ? 24'd0
                         : used_reg - {8'd0, scan.m_size};
    assign used_less_o = ({8'd0, scan.o_size} > used_reg) ? 24'd0
                         : used_reg - {8'd0, scan.o_size};
    assign add_sum     = {1'b0, (scan.m_found ? used_less_m : used_reg)}
                         + {9'd0, item_reg.item_size_mb};
    assign used_ins    = add_sum[24] ? USED_MAX : add_sum[23:0];

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        item_next   = item_reg;
        used_next   = used_reg;
        clock_next  = clock_reg;
        reload_next = reload_reg;
        evict_next  = evict_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr          = '0;
        wr.op       = WR_NONE;
        wr_idx      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    cnt_next  = '0;
                    case (item.cmd)
                        CMD_REQUEST:
                        begin
                            phase_next = PH_KEY;
                            state_next = ST_SCAN;
                        end
                        CMD_TOUCH, CMD_UNLOAD:
                        begin
                            phase_next = PH_ID;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            done_next                  = 1'b1;
                            result_next.kind           = KIND_FINAL;
                            result_next.result_id      = item.item_id;
                            result_next.was_hit        = 1'b0;
                            result_next.status         = STATUS_NOT_FOUND;
                            result_next.used_total_mb  = used_reg;
                            result_next.reload_count   = reload_reg;
                            result_next.eviction_count = evict_reg;
                            result_next.is_last        = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                result_next.kind      = KIND_FINAL;
                result_next.result_id = item_reg.item_id;
                result_next.was_hit   = 1'b0;
                result_next.status    = STATUS_OK;
                result_next.is_last   = 1'b1;
                state_next            = ST_IDLE;
                cnt_next              = '0;
                case (phase_reg)
                    PH_KEY:
                    begin
                        if (scan.m_found)
                        begin
                            wr.op                 = WR_STAMP;
                            wr.stamp              = clock_reg;
                            wr_idx                = m_idx[TABLE_ENTRIES-1];
                            clock_next            = clock_reg + 32'd1;
                            done_next             = 1'b1;
                            result_next.result_id = scan.m_id;
                            result_next.was_hit   = 1'b1;
                        end
                        else
                        begin
                            // miss: rescan by id for eviction and insert
                            reload_next = reload_reg + 32'd1;
                            phase_next  = PH_EVICT;
                            state_next  = ST_SCAN;
                        end
                    end
                    PH_EVICT:
                    begin
                        if (over && scan.o_found)
                        begin
                            wr.op                 = WR_CLEAR;
                            wr_idx                = o_idx[TABLE_ENTRIES-1];
                            used_next             = used_less_o;
                            evict_next            = evict_reg + 32'd1;
                            done_next             = 1'b1;
                            result_next.kind      = KIND_EVICT;
                            result_next.result_id = scan.o_id;
                            result_next.is_last   = 1'b0;
                            state_next            = ST_SCAN;
                        end
                        else if (scan.m_found || scan.f_found)
                        begin
                            wr.op      = WR_LOAD;
                            wr.key     = item_reg.item_key;
                            wr.id      = item_reg.item_id;
                            wr.size    = item_reg.item_size_mb;
                            wr.stamp   = clock_reg;
                            wr_idx     = scan.m_found ? m_idx[TABLE_ENTRIES-1]
                                                      : f_idx[TABLE_ENTRIES-1];
                            clock_next = clock_reg + 32'd1;
                            used_next  = used_ins;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            done_next          = 1'b1;
                            result_next.status = STATUS_FULL;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                        if (!scan.m_found)
                        begin
                            result_next.status = STATUS_NOT_FOUND;
                        end
                        else if (item_reg.cmd == CMD_TOUCH)
                        begin
                            wr.op      = WR_STAMP;
                            wr.stamp   = clock_reg;
                            wr_idx     = m_idx[TABLE_ENTRIES-1];
                            clock_next = clock_reg + 32'd1;
                        end
                        else
                        begin
                            wr.op     = WR_CLEAR;
                            wr_idx    = m_idx[TABLE_ENTRIES-1];
                            used_next = used_less_m;
                        end
                    end
                endcase
                result_next.used_total_mb  = used_next;
                result_next.reload_count   = reload_next;
                result_next.eviction_count = evict_next;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_KEY;
            cnt_reg    <= '0;
            limit_reg  <= '0;
            used_reg   <= '0;
            clock_reg  <= '0;
            reload_reg <= '0;
            evict_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            used_reg   <= used_next;
            clock_reg  <= clock_next;
            reload_reg <= reload_next;
            evict_reg  <= evict_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_last |-> !busy)
        else $error("final answer while still busy");

    a_notice_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.is_last |-> busy && result.kind == KIND_EVICT)
        else $error("eviction notice without pending command");

endmodule
